// ----- hdl/cbq_pkg.sv -----
// Shared constants, types and control structs for the cascaded biquad low-pass.
// Used by cbq_mac, cbq_hist and cascaded_biquad_lowpass. No dependencies.
package cbq_pkg;

  // Filter shape
  localparam int NUM_SECTIONS   = 2;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 28;

  // Word sizes
  localparam int COEF_BITS  = 32;
  localparam int DATA_BITS  = 32;                     // section data / history word
  localparam int PROD_BITS  = COEF_BITS + DATA_BITS;
  localparam int NUM_COEFS  = 5;
  localparam int ACC_BITS   = PROD_BITS + 3;          // exact sum of five products
  localparam int SEC_W      = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int SAMPLE_TW  = ((SAMPLE_BITS + 7) / 8) * 8;  // tdata width

  // Half LSB of the Q format, for round-half-up
  localparam logic [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

  // Unity gain in coefficient format
  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // Product step of one section; TAP_LAST only drains the product register
  typedef enum logic [2:0] {
    TAP_B0   = 3'd0,
    TAP_B1   = 3'd1,
    TAP_B2   = 3'd2,
    TAP_A1   = 3'd3,
    TAP_A2   = 3'd4,
    TAP_LAST = 3'd5
  } tap_t;

  // Sequencer to MAC unit
  typedef struct packed {
    logic clr;      // zero accumulator, drop pending product
    logic mul_en;   // take a new product this cycle
    logic rnd_en;   // round and saturate accumulator into the result register
  } mac_ctl_t;

  // Sequencer to history store
  typedef struct packed {
    logic             clr;  // zero all history
    logic             wr;   // shift in a new input/output pair
    logic [SEC_W-1:0] sec;  // section being worked on
  } hist_ctl_t;

endpackage

// ----- hdl/cbq_mac.sv -----
// Shared 32x32 multiplier with exact accumulator, rounding and 32-bit saturation.
// Depends on cbq_pkg.
module cbq_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cbq_pkg::mac_ctl_t                      ctl,
  input  logic signed [cbq_pkg::COEF_BITS-1:0]   coef,
  input  logic signed [cbq_pkg::DATA_BITS-1:0]   data,
  output logic signed [cbq_pkg::DATA_BITS-1:0]   result
);
  import cbq_pkg::*;

  logic signed [PROD_BITS-1:0] prod_r;
  logic                        prod_vld_r, prod_vld_nxt;
  logic signed [ACC_BITS-1:0]  acc_r, acc_nxt;
  logic signed [DATA_BITS-1:0] res_r;
  logic signed [ACC_BITS-1:0]  rnd_sum;
  logic signed [ACC_BITS-1:0]  rnd_shf;
  logic [ACC_BITS-DATA_BITS:0] rnd_top;
  logic signed [DATA_BITS-1:0] res_sat;

  // Product register: one multiply per cycle while mul_en is set
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= coef * data;
    end
  end

  // Accumulate the product taken on the previous cycle
  always_comb begin
    prod_vld_nxt = ctl.mul_en;
    acc_nxt      = acc_r;
    if (ctl.clr) begin
      prod_vld_nxt = 1'b0;
      acc_nxt      = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + ACC_BITS'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= prod_vld_nxt;
      acc_r      <= acc_nxt;
    end
  end

  // Round half up, drop fraction, clamp to 32-bit signed
  always_comb begin
    rnd_sum = acc_r + $signed(RND_HALF);
    rnd_shf = rnd_sum >>> COEF_FRAC_BITS;
    rnd_top = rnd_shf[ACC_BITS-1:DATA_BITS-1];
    if ((&rnd_top) || (~|rnd_top)) begin
      res_sat = rnd_shf[DATA_BITS-1:0];
    end else if (rnd_shf[ACC_BITS-1]) begin
      res_sat = {1'b1, {(DATA_BITS-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(DATA_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rnd_en) begin
      res_r <= res_sat;
    end
  end

  assign result = res_r;

endmodule

// ----- hdl/cbq_hist.sv -----
// Per-section input and output history (two samples back) for the biquad cascade.
// Depends on cbq_pkg.
module cbq_hist (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cbq_pkg::hist_ctl_t                    ctl,
  input  logic signed [cbq_pkg::DATA_BITS-1:0]  x_in,
  input  logic signed [cbq_pkg::DATA_BITS-1:0]  y_in,
  output logic signed [cbq_pkg::DATA_BITS-1:0]  x1,
  output logic signed [cbq_pkg::DATA_BITS-1:0]  x2,
  output logic signed [cbq_pkg::DATA_BITS-1:0]  y1,
  output logic signed [cbq_pkg::DATA_BITS-1:0]  y2
);
  import cbq_pkg::*;

  logic signed [DATA_BITS-1:0] x1_r [NUM_SECTIONS];
  logic signed [DATA_BITS-1:0] x2_r [NUM_SECTIONS];
  logic signed [DATA_BITS-1:0] y1_r [NUM_SECTIONS];
  logic signed [DATA_BITS-1:0] y2_r [NUM_SECTIONS];

  // Clear wins; otherwise shift the selected section's delay line
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int s = 0; s < NUM_SECTIONS; s++) begin
        x1_r[s] <= '0;
        x2_r[s] <= '0;
        y1_r[s] <= '0;
        y2_r[s] <= '0;
      end
    end else if (ctl.wr) begin
      x2_r[ctl.sec] <= x1_r[ctl.sec];
      x1_r[ctl.sec] <= x_in;
      y2_r[ctl.sec] <= y1_r[ctl.sec];
      y1_r[ctl.sec] <= y_in;
    end
  end

  // Read port for the active section
  assign x1 = x1_r[ctl.sec];
  assign x2 = x2_r[ctl.sec];
  assign y1 = y1_r[ctl.sec];
  assign y2 = y2_r[ctl.sec];

endmodule

// ----- hdl/cascaded_biquad_lowpass.sv -----
// Top level: two-section cascaded biquad low-pass on one shared multiplier.
// Depends on cbq_pkg, cbq_mac, cbq_hist.
//
//  channel  | dir | payload                                   | request when
//  ---------+-----+-------------------------------------------+-------------------------
//  in_      | in  | tdata: sample_in[23:0]; tuser: clear_hist | in_tvalid & in_tready
//  out_     | out | tdata: sample_out[23:0]                   | out_tvalid & out_tready
//  cfg_     | in  | index 0..4 = b0,b1,b2,a1,a2; data 32 bits | cfg_valid & cfg_ready
//
// Per sample: an accept state, then per section five products plus a drain step on the
// shared multiplier, a round step and a history write, then the output register is
// loaded. in_tready is high only while idle; a result not yet taken holds the load
// state, and no new sample is accepted while it waits. cfg_ready is always high.
// Synchronous reset clears history, sets b0 to unity and the other coefficients to zero.
module cascaded_biquad_lowpass (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [cbq_pkg::SAMPLE_TW-1:0]          in_tdata,   // [23:0] sample_in
  input  logic                                   in_tuser,   // [0] clear_history
  // result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [cbq_pkg::SAMPLE_TW-1:0]          out_tdata,  // [23:0] sample_out
  // coefficient writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cbq_pkg::COEF_BITS-1:0]          cfg_data
);
  import cbq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_RND  = 5'b00100,
    ST_WB   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  tap_t                        tap_r, tap_nxt;
  logic [SEC_W-1:0]            sec_r, sec_nxt;
  logic signed [DATA_BITS-1:0] x_r, x_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic [SAMPLE_BITS-1:0]      out_data_r, out_data_nxt;
  logic signed [COEF_BITS-1:0] coef_r [NUM_COEFS];

  mac_ctl_t                    mac_ctl;
  hist_ctl_t                   hist_ctl;
  logic signed [COEF_BITS-1:0] mul_coef;
  logic signed [DATA_BITS-1:0] mul_data;
  logic signed [DATA_BITS-1:0] sec_y;
  logic signed [DATA_BITS-1:0] h_x1, h_x2, h_y1, h_y2;
  logic                        in_acc;
  logic [DATA_BITS-SAMPLE_BITS:0] x_top;
  logic [SAMPLE_BITS-1:0]      x_sat;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = SAMPLE_TW'(out_data_r);

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= $signed(COEF_ONE);
      for (int i = 1; i < NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_B0:  coef_r[0] <= cfg_data;
        REG_B1:  coef_r[1] <= cfg_data;
        REG_B2:  coef_r[2] <= cfg_data;
        REG_A1:  coef_r[3] <= cfg_data;
        REG_A2:  coef_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    case (tap_r)
      TAP_B0:  begin mul_coef = coef_r[0]; mul_data = x_r;  end
      TAP_B1:  begin mul_coef = coef_r[1]; mul_data = h_x1; end
      TAP_B2:  begin mul_coef = coef_r[2]; mul_data = h_x2; end
      TAP_A1:  begin mul_coef = coef_r[3]; mul_data = h_y1; end
      TAP_A2:  begin mul_coef = coef_r[4]; mul_data = h_y2; end
      default: begin mul_coef = '0;        mul_data = '0;   end
    endcase
  end

  // Final clamp to the sample range
  always_comb begin
    x_top = x_r[DATA_BITS-1:SAMPLE_BITS-1];
    if ((&x_top) || (~|x_top)) begin
      x_sat = x_r[SAMPLE_BITS-1:0];
    end else if (x_r[DATA_BITS-1]) begin
      x_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      x_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    tap_nxt      = tap_r;
    sec_nxt      = sec_r;
    x_nxt        = x_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    mac_ctl      = '0;
    hist_ctl     = '0;
    hist_ctl.sec = sec_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt        = DATA_BITS'($signed(in_tdata[SAMPLE_BITS-1:0]));
          sec_nxt      = '0;
          tap_nxt      = TAP_B0;
          hist_ctl.clr = in_tuser;
          mac_ctl.clr  = 1'b1;
          state_nxt    = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctl.mul_en = (tap_r != TAP_LAST);
        if (tap_r == TAP_LAST) begin
          state_nxt = ST_RND;
        end else begin
          tap_nxt = tap_t'(tap_r + 3'd1);
        end
      end
      ST_RND: begin
        mac_ctl.rnd_en = 1'b1;
        state_nxt      = ST_WB;
      end
      ST_WB: begin
        hist_ctl.wr = 1'b1;
        x_nxt       = sec_y;
        if (sec_r == SEC_W'(NUM_SECTIONS - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          sec_nxt     = sec_r + SEC_W'(1);
          tap_nxt     = TAP_B0;
          mac_ctl.clr = 1'b1;
          state_nxt   = ST_MAC;
        end
      end
      ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = x_sat;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      tap_r     <= TAP_B0;
      sec_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tap_r     <= tap_nxt;
      sec_r     <= sec_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    out_data_r <= out_data_nxt;
  end

  cbq_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .coef   (mul_coef),
    .data   (mul_data),
    .result (sec_y)
  );

  cbq_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (hist_ctl),
    .x_in  (x_r),
    .y_in  (sec_y),
    .x1    (h_x1),
    .x2    (h_x2),
    .y1    (h_y1),
    .y2    (h_y2)
  );

endmodule
